// File: rtl/lsa_pkg.sv
// Package for the LIFO stack allocator: widths, buffer and header geometry,
// request and status codes, and the header slot and block check functions.
// Depends on nothing.
package lsa_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int HEADER_BYTES = 24;
    localparam int HEADER_ALIGN = 8;
    localparam int STORE_DEPTH  = BUFFER_BYTES / HEADER_ALIGN;

    localparam int OFS_W       = 13;
    localparam int REQ_W       = 3;
    localparam int ALIGN_W     = 4;
    localparam int STATUS_W    = 3;
    localparam int WIDE_W      = 18;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int ALIGN_SHIFT = $clog2(HEADER_ALIGN);
    localparam int IDX_W       = OFS_W - ALIGN_SHIFT;

    localparam logic [WIDE_W-1:0] HDR_ALIGN_MASK = WIDE_W'(HEADER_ALIGN - 1);

    localparam logic [REQ_W-1:0] REQ_ALLOC     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR_TO  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REALLOC   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_SUCCESS   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_BLOCK = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 3'd4;

    // Header slot of a block. Offsets that fall outside the store map to slot zero.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [OFS_W-1:0] blk);
        logic [OFS_W-1:0] rel;
        logic [IDX_W-1:0] idx;
        rel = blk - OFS_W'(HEADER_BYTES);
        idx = rel[OFS_W-1:ALIGN_SHIFT];
        if (blk < OFS_W'(HEADER_BYTES) || idx >= IDX_W'(STORE_DEPTH)) begin
            slot_of = '0;
        end else begin
            slot_of = idx[SLOT_W-1:0];
        end
    endfunction

    function automatic logic block_ok(input logic [OFS_W-1:0] blk,
                                      input logic [OFS_W-1:0] top);
        logic [OFS_W-1:0] rel;
        rel = blk - OFS_W'(HEADER_BYTES);
        block_ok = (blk >= OFS_W'(HEADER_BYTES)) && (blk <= top) &&
                   (rel[ALIGN_SHIFT-1:0] == '0);
    endfunction

endpackage

// File: rtl/lifo_stack_allocator.sv
// LIFO stack allocator: request sequencer, shared adder and header store.
// Depends on lsa_pkg.
//
// Usage: requests arrive as beats on the s_ channel (valid/ready) and each one
// produces exactly one result beat on the m_ channel (valid/ready). The single
// capacity register is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this. A request
// occupies the block from acceptance until its result is loaded into the output
// register; s_ready is low meanwhile. One shared adder steps through the alignment,
// header and end-of-block sums one per cycle, and the header store answers a read
// in the cycle after its address is set. A new request can be accepted in the cycle
// after the previous result is loaded. When the receiver stalls, a finished result
// waits in the output register and the block may accept and work on one further
// request; that request then holds in its final step until the output register is
// free. Reset clears the offsets, restores the capacity to the full buffer and
// empties the output register. Header entries are not cleared, and the block check
// tests only bounds and alignment, so an entry that was never written can be read.
module lifo_stack_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lsa_pkg::OFS_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lsa_pkg::REQ_W-1:0]      s_req_type,
    input  logic [lsa_pkg::OFS_W-1:0]      s_size_bytes,
    input  logic [lsa_pkg::ALIGN_W-1:0]    s_alignment_log2,
    input  logic [lsa_pkg::OFS_W-1:0]      s_block_offset,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lsa_pkg::STATUS_W-1:0]   m_status,
    output logic [lsa_pkg::OFS_W-1:0]      m_result_offset,
    output logic [lsa_pkg::OFS_W-1:0]      m_copy_bytes,
    output logic [lsa_pkg::OFS_W-1:0]      m_used_bytes
);
    import lsa_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b00_0000_0001,
        ST_DECODE     = 10'b00_0000_0010,
        ST_READ       = 10'b00_0000_0100,
        ST_ALIGN_REQ  = 10'b00_0000_1000,
        ST_ALIGN_HDR  = 10'b00_0001_0000,
        ST_ADD_HDR    = 10'b00_0010_0000,
        ST_CHECK      = 10'b00_0100_0000,
        ST_COMMIT     = 10'b00_1000_0000,
        ST_TOP_RESIZE = 10'b01_0000_0000,
        ST_DONE       = 10'b10_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [REQ_W-1:0]      req_reg;
    logic [OFS_W-1:0]      size_reg;
    logic [ALIGN_W-1:0]    lg_reg;
    logic [OFS_W-1:0]      blk_reg;
    logic [OFS_W-1:0]      cap_reg;
    logic [OFS_W-1:0]      free_reg, free_next;
    logic [OFS_W-1:0]      top_reg, top_next;
    logic [WIDE_W-1:0]     acc_reg, acc_next;
    logic [WIDE_W-1:0]     end_reg, end_next;
    logic [OFS_W-1:0]      old_size_reg, old_size_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [OFS_W-1:0]      result_reg, result_next;
    logic [OFS_W-1:0]      copy_reg, copy_next;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [OFS_W-1:0]      m_result_reg, m_copy_reg, m_used_reg;

    logic [OFS_W-1:0]      pad_mem  [STORE_DEPTH];
    logic [OFS_W-1:0]      size_mem [STORE_DEPTH];
    logic [OFS_W-1:0]      prev_mem [STORE_DEPTH];
    logic [OFS_W-1:0]      rd_pad_reg, rd_size_reg, rd_prev_reg;
    logic [SLOT_W-1:0]     rd_addr, wr_addr;
    logic                  hdr_we, size_we;

    logic [OFS_W-1:0]      eff_cap;
    logic [WIDE_W-1:0]     amask;
    logic [OFS_W-1:0]      target;
    logic                  blk_valid;
    logic [WIDE_W-1:0]     unit_a, unit_b, unit_sum;
    logic                  unit_sub;
    logic                  over_cap;
    logic                  load_out;

    assign s_ready   = (state_reg == ST_IDLE);
    assign eff_cap   = (cap_reg > OFS_W'(BUFFER_BYTES)) ? OFS_W'(BUFFER_BYTES) : cap_reg;
    assign amask     = (WIDE_W'(1) << lg_reg) - WIDE_W'(1);
    assign target    = (req_reg == REQ_POP) ? top_reg : blk_reg;
    assign blk_valid = block_ok(blk_reg, top_reg);
    assign rd_addr   = slot_of(target);
    assign wr_addr   = (state_reg == ST_COMMIT) ? slot_of(acc_reg[OFS_W-1:0]) : slot_of(blk_reg);

    // The one adder shared by the read, alignment, header, check, commit and resize steps.
    always_comb begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
        case (state_reg)
            ST_READ: begin
                unit_a   = WIDE_W'(target);
                unit_b   = WIDE_W'(rd_pad_reg);
                unit_sub = 1'b1;
            end
            ST_ALIGN_REQ: begin
                unit_a = WIDE_W'(free_reg);
                unit_b = amask;
            end
            ST_ALIGN_HDR: begin
                unit_a = acc_reg;
                unit_b = HDR_ALIGN_MASK;
            end
            ST_ADD_HDR: begin
                unit_a = acc_reg;
                unit_b = WIDE_W'(HEADER_BYTES);
            end
            ST_CHECK: begin
                unit_a = acc_reg;
                unit_b = WIDE_W'(size_reg);
            end
            ST_COMMIT: begin
                unit_a   = acc_reg;
                unit_b   = WIDE_W'(free_reg);
                unit_sub = 1'b1;
            end
            ST_TOP_RESIZE: begin
                unit_a = WIDE_W'(blk_reg);
                unit_b = WIDE_W'(size_reg);
            end
            default: begin
                unit_a = '0;
            end
        endcase
        unit_sum = unit_sub ? (unit_a - unit_b) : (unit_a + unit_b);
        over_cap = unit_sum > WIDE_W'(eff_cap);
    end

    always_comb begin
        state_next    = state_reg;
        free_next     = free_reg;
        top_next      = top_reg;
        acc_next      = acc_reg;
        end_next      = end_reg;
        old_size_next = old_size_reg;
        status_next   = status_reg;
        result_next   = result_reg;
        copy_next     = copy_reg;
        hdr_we        = 1'b0;
        size_we       = 1'b0;
        load_out      = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    status_next = STATUS_SUCCESS;
                    result_next = '0;
                    copy_next   = '0;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (req_reg)
                    REQ_ALLOC: begin
                        if (size_reg == '0) begin
                            status_next = STATUS_ZERO_SIZE;
                            state_next  = ST_DONE;
                        end else begin
                            state_next = ST_ALIGN_REQ;
                        end
                    end
                    REQ_POP, REQ_CLEAR_TO: begin
                        if (top_reg == '0) begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_DONE;
                        end else if (req_reg == REQ_CLEAR_TO && !blk_valid) begin
                            status_next = STATUS_BAD_BLOCK;
                            state_next  = ST_DONE;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    REQ_REALLOC: begin
                        if (size_reg == '0) begin
                            status_next = STATUS_ZERO_SIZE;
                            state_next  = ST_DONE;
                        end else if (top_reg == '0) begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_DONE;
                        end else if (!blk_valid) begin
                            status_next = STATUS_BAD_BLOCK;
                            state_next  = ST_DONE;
                        end else if (blk_reg == top_reg) begin
                            state_next = ST_TOP_RESIZE;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    REQ_CLEAR_ALL: begin
                        free_next  = '0;
                        top_next   = '0;
                        state_next = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ: begin
                if (req_reg == REQ_REALLOC) begin
                    old_size_next = rd_size_reg;
                    state_next    = ST_ALIGN_REQ;
                end else begin
                    free_next  = unit_sum[WIDE_W-1] ? '0 : unit_sum[OFS_W-1:0];
                    top_next   = rd_prev_reg;
                    state_next = ST_DONE;
                end
            end
            ST_ALIGN_REQ: begin
                acc_next   = unit_sum & ~amask;
                state_next = ST_ALIGN_HDR;
            end
            ST_ALIGN_HDR: begin
                acc_next   = unit_sum & ~HDR_ALIGN_MASK;
                state_next = ST_ADD_HDR;
            end
            ST_ADD_HDR: begin
                acc_next   = unit_sum;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                end_next = unit_sum;
                if (free_reg > eff_cap || over_cap) begin
                    status_next = STATUS_NO_SPACE;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                hdr_we      = 1'b1;
                top_next    = acc_reg[OFS_W-1:0];
                free_next   = end_reg[OFS_W-1:0];
                result_next = acc_reg[OFS_W-1:0];
                if (req_reg == REQ_REALLOC) begin
                    copy_next = (old_size_reg < size_reg) ? old_size_reg : size_reg;
                end
                state_next = ST_DONE;
            end
            ST_TOP_RESIZE: begin
                if (over_cap) begin
                    status_next = STATUS_NO_SPACE;
                end else begin
                    size_we     = 1'b1;
                    free_next   = unit_sum[OFS_W-1:0];
                    result_next = blk_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= OFS_W'(BUFFER_BYTES);
            free_reg    <= '0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            free_reg    <= free_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg  <= s_req_type;
            size_reg <= s_size_bytes;
            lg_reg   <= s_alignment_log2;
            blk_reg  <= s_block_offset;
        end
        acc_reg      <= acc_next;
        end_reg      <= end_next;
        old_size_reg <= old_size_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
        copy_reg     <= copy_next;
        if (load_out) begin
            m_status_reg <= status_reg;
            m_result_reg <= result_reg;
            m_copy_reg   <= copy_reg;
            m_used_reg   <= free_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            pad_mem[wr_addr]  <= unit_sum[OFS_W-1:0];
            prev_mem[wr_addr] <= top_reg;
        end
        if (hdr_we || size_we) begin
            size_mem[wr_addr] <= size_reg;
        end
        rd_pad_reg  <= pad_mem[rd_addr];
        rd_size_reg <= size_mem[rd_addr];
        rd_prev_reg <= prev_mem[rd_addr];
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_offset = m_result_reg;
    assign m_copy_bytes    = m_copy_reg;
    assign m_used_bytes    = m_used_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Block took a second beat right after accepting one.");

    a_fail_clears_offsets: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_SUCCESS) |->
            (m_result_offset == '0) && (m_copy_bytes == '0))
        else $error("A failed request reported a block or a copy length.");

    a_block_above_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_offset != '0) |-> m_result_offset >= OFS_W'(HEADER_BYTES))
        else $error("A block offset leaves no room for its header.");

    a_copy_needs_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_copy_bytes != '0) |-> (m_result_offset != '0))
        else $error("A copy length was reported without a new block.");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lifo_stack_allocator: random and directed request
// beats, a scoreboard class that predicts each result, and a result checker.
// Depends on lsa_pkg and the lifo_stack_allocator RTL.
module tb;
    import lsa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 200;
    localparam int NUM_PHASES   = 7;

    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [OFS_W-1:0]   size;
        logic [ALIGN_W-1:0] align_lg;
        logic [OFS_W-1:0]   block;
    } alloc_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFS_W-1:0]    offset;
        logic [OFS_W-1:0]    copy;
        logic [OFS_W-1:0]    used;
    } alloc_resp_t;

    typedef int block_list_t[$];

    class alloc_scoreboard;
        bit [OFS_W-1:0] capacity;
        bit [OFS_W-1:0] free_ofs;
        bit [OFS_W-1:0] top_ofs;
        bit [OFS_W-1:0] hdr_pad[STORE_DEPTH];
        bit [OFS_W-1:0] hdr_size[STORE_DEPTH];
        bit [OFS_W-1:0] hdr_prev[STORE_DEPTH];
        bit             hdr_written[STORE_DEPTH];
        alloc_resp_t    expected_resp[$];
        int             errors;

        function new();
            capacity = OFS_W'(BUFFER_BYTES);
            free_ofs = '0;
            top_ofs = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_resp.size();
        endfunction

        function int slot_index(int blk);
            int idx;
            if (blk < HEADER_BYTES) return 0;
            idx = (blk - HEADER_BYTES) / HEADER_ALIGN;
            return (idx < STORE_DEPTH) ? idx : 0;
        endfunction

        function bit block_valid(int blk);
            return blk >= HEADER_BYTES && blk <= int'(top_ofs) &&
                   ((blk - HEADER_BYTES) % HEADER_ALIGN) == 0;
        endfunction

        // A live-looking block whose header was never written must not be touched.
        function bit header_unwritten(int blk);
            return top_ofs != 0 && block_valid(blk) && !hdr_written[slot_index(blk)];
        endfunction

        function int usable_bytes();
            return (int'(capacity) < BUFFER_BYTES) ? int'(capacity) : BUFFER_BYTES;
        endfunction

        function block_list_t live_blocks();
            block_list_t q;
            int b;
            b = int'(top_ofs);
            while (b != 0 && q.size() < STORE_DEPTH) begin
                q.push_back(b);
                b = int'(hdr_prev[slot_index(b)]);
            end
            return q;
        endfunction

        // Returns the new block, or zero when the request does not fit.
        function int try_alloc(int size, int lg);
            int cap, align, pad, rem, blk, s;
            cap = usable_bytes();
            align = 1 << lg;
            pad = 0;
            rem = int'(free_ofs) & (align - 1);
            if (rem != 0) pad += align - rem;
            rem = (int'(free_ofs) + pad) % HEADER_ALIGN;
            if (rem != 0) pad += HEADER_ALIGN - rem;
            pad += HEADER_BYTES;
            if (int'(free_ofs) > cap || pad + size > cap - int'(free_ofs)) return 0;
            blk = int'(free_ofs) + pad;
            s = slot_index(blk);
            hdr_pad[s] = OFS_W'(pad);
            hdr_size[s] = OFS_W'(size);
            hdr_prev[s] = top_ofs;
            hdr_written[s] = 1'b1;
            top_ofs = OFS_W'(blk);
            free_ofs = OFS_W'(blk + size);
            return blk;
        endfunction

        function alloc_resp_t predict_request(alloc_req_t r);
            alloc_resp_t resp;
            int size, blk, base, s, old_size;
            size = int'(r.size);
            blk = int'(r.block);
            resp = '0;
            case (r.kind)
                REQ_ALLOC: begin
                    if (size == 0) begin
                        resp.status = STATUS_ZERO_SIZE;
                    end else begin
                        resp.offset = OFS_W'(try_alloc(size, int'(r.align_lg)));
                        if (resp.offset == 0) resp.status = STATUS_NO_SPACE;
                    end
                end
                REQ_POP, REQ_CLEAR_TO: begin
                    if (top_ofs == 0) begin
                        resp.status = STATUS_EMPTY;
                    end else if (r.kind == REQ_CLEAR_TO && !block_valid(blk)) begin
                        resp.status = STATUS_BAD_BLOCK;
                    end else begin
                        base = (r.kind == REQ_POP) ? int'(top_ofs) : blk;
                        s = slot_index(base);
                        free_ofs = (base >= int'(hdr_pad[s])) ?
                                   OFS_W'(base - int'(hdr_pad[s])) : '0;
                        top_ofs = hdr_prev[s];
                    end
                end
                REQ_REALLOC: begin
                    if (size == 0) begin
                        resp.status = STATUS_ZERO_SIZE;
                    end else if (top_ofs == 0) begin
                        resp.status = STATUS_EMPTY;
                    end else if (!block_valid(blk)) begin
                        resp.status = STATUS_BAD_BLOCK;
                    end else if (blk == int'(top_ofs)) begin
                        if (blk + size > usable_bytes()) begin
                            resp.status = STATUS_NO_SPACE;
                        end else begin
                            hdr_size[slot_index(blk)] = OFS_W'(size);
                            free_ofs = OFS_W'(blk + size);
                            resp.offset = r.block;
                        end
                    end else begin
                        old_size = int'(hdr_size[slot_index(blk)]);
                        resp.offset = OFS_W'(try_alloc(size, int'(r.align_lg)));
                        if (resp.offset == 0) begin
                            resp.status = STATUS_NO_SPACE;
                        end else begin
                            resp.copy = OFS_W'((old_size < size) ? old_size : size);
                        end
                    end
                end
                REQ_CLEAR_ALL: begin
                    free_ofs = '0;
                    top_ofs = '0;
                end
                default: ;
            endcase
            resp.used = free_ofs;
            return resp;
        endfunction

        function void note_request(alloc_req_t r);
            expected_resp.push_back(predict_request(r));
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
        endfunction

        function void check_result(alloc_resp_t got);
            alloc_resp_t want;
            if (expected_resp.size() == 0) begin
                report_error($sformatf(
                    "unexpected result beat: status %0d offset %0d copy %0d used %0d",
                    got.status, got.offset, got.copy, got.used));
                return;
            end
            want = expected_resp.pop_front();
            if (got.status !== want.status || got.offset !== want.offset ||
                got.copy !== want.copy || got.used !== want.used) begin
                report_error($sformatf({"expected status %0d offset %0d copy %0d used %0d,",
                    " got status %0d offset %0d copy %0d used %0d"},
                    want.status, want.offset, want.copy, want.used,
                    got.status, got.offset, got.copy, got.used));
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we;
    logic [OFS_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type;
    logic [OFS_W-1:0]    s_size_bytes;
    logic [ALIGN_W-1:0]  s_alignment_log2;
    logic [OFS_W-1:0]    s_block_offset;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [OFS_W-1:0]    m_result_offset;
    logic [OFS_W-1:0]    m_copy_bytes;
    logic [OFS_W-1:0]    m_used_bytes;

    alloc_scoreboard sb;
    int cycle_count = 0;
    int hold_left = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int phase_cap[NUM_PHASES]   = '{4096, 300, 4096, 1024, 0, 64, 4096};
    int phase_items[NUM_PHASES] = '{400, 250, 350, 300, 50, 100, 250};

    lifo_stack_allocator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_size_bytes     (s_size_bytes),
        .s_alignment_log2 (s_alignment_log2),
        .s_block_offset   (s_block_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_result_offset  (m_result_offset),
        .m_copy_bytes     (m_copy_bytes),
        .m_used_bytes     (m_used_bytes)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_status, m_result_offset, m_copy_bytes, m_used_bytes});
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (idle_on && !rx_calm && $urandom_range(5) == 0) begin
            m_ready = 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            m_ready = 1'b1;
        end
        if ($urandom_range(79) == 0) rx_calm = !rx_calm;
    end

    function automatic alloc_req_t make_req(input int kind, input int size,
                                            input int lg, input int blk);
        alloc_req_t r;
        r.kind = REQ_W'(kind);
        r.size = OFS_W'(size);
        r.align_lg = ALIGN_W'(lg);
        r.block = OFS_W'(blk);
        return r;
    endfunction

    // Mostly well-formed traffic against live blocks, with some raw noise.
    function automatic alloc_req_t make_random_request();
        alloc_req_t r;
        block_list_t live;
        int roll, size;
        live = sb.live_blocks();
        roll = $urandom_range(99);
        if (roll < 4) size = 0;
        else if (roll < 9) size = $urandom_range(BUFFER_BYTES, 1);
        else size = $urandom_range(160, 1);
        r = make_req(REQ_ALLOC, size,
                     ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(4),
                     $urandom_range(BUFFER_BYTES));
        roll = $urandom_range(99);
        if (roll < 40) begin
            r.kind = REQ_ALLOC;
        end else if (roll < 54) begin
            r.kind = REQ_POP;
        end else if (roll < 64) begin
            r.kind = REQ_CLEAR_TO;
            if (live.size() > 0) r.block = OFS_W'(live[$urandom_range(live.size() - 1)]);
        end else if (roll < 80) begin
            r.kind = REQ_REALLOC;
            if (live.size() > 0) begin
                r.block = OFS_W'(($urandom_range(1) == 0) ? live[0] :
                                 live[$urandom_range(live.size() - 1)]);
            end
        end else if (roll < 83) begin
            r.kind = REQ_CLEAR_ALL;
        end else if (roll < 86) begin
            r.kind = REQ_W'($urandom_range(int'(REQ_SPARE_LAST), int'(REQ_SPARE_FIRST)));
        end else begin
            r.kind = REQ_W'($urandom_range(int'(REQ_CLEAR_ALL)));
            r.size = OFS_W'($urandom_range(BUFFER_BYTES));
            r.align_lg = ALIGN_W'($urandom_range(12));
            if ($urandom_range(1) == 0) begin
                r.block = OFS_W'(HEADER_BYTES + HEADER_ALIGN * $urandom_range(40));
            end
        end
        return r;
    endfunction

    task automatic drive_item(input alloc_req_t r);
        @(negedge aclk);
        s_valid = 1'b1;
        s_req_type = r.kind;
        s_size_bytes = r.size;
        s_alignment_log2 = r.align_lg;
        s_block_offset = r.block;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
    endtask

    task automatic issue(input alloc_req_t r);
        int gap;
        if ((r.kind == REQ_CLEAR_TO || r.kind == REQ_REALLOC) &&
            sb.header_unwritten(int'(r.block))) begin
            r.block = sb.top_ofs;
        end
        if (idle_on && !tx_calm && $urandom_range(4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        if ($urandom_range(39) == 0) tx_calm = !tx_calm;
        drive_item(r);
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input int value);
        pause_until_drained();
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = OFS_W'(value);
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.capacity = OFS_W'(value);
    endtask

    initial begin
        int p, i;
        sb = new();
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_req_type = REQ_ALLOC;
        s_size_bytes = '0;
        s_alignment_log2 = '0;
        s_block_offset = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Empty stack and zero-size requests first, then a small stack to work on.
        issue(make_req(REQ_POP, 0, 0, 0));
        issue(make_req(REQ_CLEAR_TO, 0, 0, 24));
        issue(make_req(REQ_REALLOC, 5, 0, 24));
        issue(make_req(REQ_ALLOC, 0, 0, 0));
        issue(make_req(REQ_REALLOC, 0, 0, 24));
        issue(make_req(REQ_ALLOC, 4096, 0, 0));
        issue(make_req(REQ_ALLOC, 1, 12, 0));
        issue(make_req(REQ_ALLOC, 100, 12, 0));
        issue(make_req(REQ_ALLOC, 40, 3, 0));
        issue(make_req(REQ_ALLOC, 16, 5, 0));
        issue(make_req(REQ_CLEAR_TO, 0, 0, 23));
        issue(make_req(REQ_CLEAR_TO, 0, 0, 57));
        issue(make_req(REQ_CLEAR_TO, 0, 0, 4096));
        issue(make_req(REQ_REALLOC, 200, 0, 120));
        issue(make_req(REQ_REALLOC, 4096, 0, 120));
        issue(make_req(REQ_REALLOC, 8, 0, 24));
        issue(make_req(REQ_POP, 0, 0, 0));
        issue(make_req(REQ_CLEAR_TO, 0, 0, 56));
        for (i = int'(REQ_SPARE_FIRST); i <= int'(REQ_SPARE_LAST); i++) begin
            issue(make_req(i, $urandom_range(BUFFER_BYTES), $urandom_range(12),
                           $urandom_range(BUFFER_BYTES)));
        end
        issue(make_req(REQ_CLEAR_ALL, 0, 0, 0));
        issue(make_req(REQ_ALLOC, 4072, 0, 0));
        issue(make_req(REQ_ALLOC, 1, 0, 0));
        issue(make_req(REQ_POP, 0, 0, 0));
        issue(make_req(REQ_ALLOC, 1000, 0, 0));

        // Capacity drops below the current free offset.
        write_capacity(0);
        issue(make_req(REQ_ALLOC, 1, 0, 0));
        issue(make_req(REQ_REALLOC, 1, 0, 24));
        issue(make_req(REQ_CLEAR_ALL, 0, 0, 0));

        for (p = 0; p < NUM_PHASES; p++) begin
            write_capacity(phase_cap[p]);
            if (p == NUM_PHASES - 1) idle_on = 1'b0;
            for (i = 0; i < phase_items[p]; i++) begin
                if (p == 2 && i == 100) hold_left = HOLD_CYCLES;
                if (p == 2 && i == 250) pause_until_drained();
                issue(make_random_request());
            end
        end

        pause_until_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: lifo_stack_allocator.f
rtl/lsa_pkg.sv
rtl/lifo_stack_allocator.sv
dv/tb.sv
